>>> rtl/core/dq_pkg.sv
package dq_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned COUNT_W   = 5;
  localparam int unsigned DEPTH_DEF = 16;

  typedef enum logic [1:0] {
    MODE_PUSH_FRONT = 2'd0,
    MODE_PUSH_REAR  = 2'd1,
    MODE_POP_FRONT  = 2'd2,
    MODE_POP_REAR   = 2'd3
  } dq_mode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } dq_status_e;

  // What every cell of a row does when the row is clocked.
  typedef enum logic [1:0] {
    OP_HOLD     = 2'd0,
    OP_INS_HEAD = 2'd1,
    OP_REM_HEAD = 2'd2,
    OP_INS_AT   = 2'd3
  } dq_cell_op_e;

  typedef struct packed {
    dq_cell_op_e        op;
    logic [WORD_W-1:0]  word;
  } dq_ctrl_t;

endpackage

>>> rtl/core/dq_if.sv
interface dq_req_if;
  import dq_pkg::*;

  logic                      valid;
  logic                      ready;
  dq_mode_e                  mode;
  logic signed [WORD_W-1:0]  value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface dq_rsp_if;
  import dq_pkg::*;

  logic                      valid;
  logic                      ready;
  dq_status_e                status;
  logic signed [WORD_W-1:0]  front_word;
  logic signed [WORD_W-1:0]  rear_word;
  logic [COUNT_W-1:0]        count;
  logic                      is_empty;

  modport source (output valid, output status, output front_word, output rear_word,
                  output count, output is_empty, input ready);
  modport sink   (input valid, input status, input front_word, input rear_word,
                  input count, input is_empty, output ready);
endinterface

>>> rtl/core/dq_cell.sv
module dq_cell #(
  parameter int unsigned CNT_W = 5,
  parameter int unsigned IDX   = 0
) (
  input  logic                        clk_i,
  input  dq_pkg::dq_ctrl_t            ctrl_i,
  input  logic [CNT_W-1:0]            count_i,
  input  logic [dq_pkg::WORD_W-1:0]   lower_i,
  input  logic [dq_pkg::WORD_W-1:0]   upper_i,
  output logic [dq_pkg::WORD_W-1:0]   word_o
);
  import dq_pkg::*;

  logic [WORD_W-1:0] word_q;
  logic [WORD_W-1:0] word_d;

  // A cell takes from the neighbor nearer the head on an insert, from the
  // neighbor farther away on a removal, or loads the new word when it is
  // the first free place.
  always_comb begin
    word_d = word_q;
    case (ctrl_i.op)
      OP_INS_HEAD: word_d = lower_i;
      OP_REM_HEAD: word_d = upper_i;
      OP_INS_AT: begin
        if (count_i == CNT_W'(IDX)) begin
          word_d = ctrl_i.word;
        end
      end
      default: word_d = word_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

>>> rtl/core/dq_chain.sv
module dq_chain #(
  parameter int unsigned DEPTH = dq_pkg::DEPTH_DEF,
  parameter int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                        clk_i,
  input  dq_pkg::dq_ctrl_t            ctrl_i,
  input  logic [CNT_W-1:0]            count_i,
  output logic [dq_pkg::WORD_W-1:0]   head_o,
  output logic [dq_pkg::WORD_W-1:0]   second_o
);
  import dq_pkg::*;

  logic [DEPTH-1:0][WORD_W-1:0] words;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_W-1:0] lower;
    logic [WORD_W-1:0] upper;

    if (i == 0) begin : g_first
      assign lower = ctrl_i.word;
    end else begin : g_lower
      assign lower = words[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign upper = words[i];
    end else begin : g_upper
      assign upper = words[i+1];
    end

    dq_cell #(
      .CNT_W (CNT_W),
      .IDX   (i)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl_i),
      .count_i (count_i),
      .lower_i (lower),
      .upper_i (upper),
      .word_o  (words[i])
    );
  end

  assign head_o   = words[0];
  assign second_o = words[1];

endmodule

>>> rtl/core/double_ended_queue_top.sv
// Channel   Direction  Handshake      Payload
// req_i     in         valid / ready  mode, value
// rsp_o     out        valid / ready  status, front_word, rear_word, count, is_empty
//
// One item is taken per cycle while the output register is empty or its result is taken;
// the result then sits in the output register in the cycle after. Both rows update with it.
// Reset clears the word count and the output valid; the cells themselves are not reset.
// A stalled result blocks new items only while it is not taken (ready = !valid || taken).
module double_ended_queue_top #(
  parameter int unsigned DEPTH = dq_pkg::DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dq_req_if.sink    req_i,
  dq_rsp_if.source  rsp_o
);
  import dq_pkg::*;

  // The contents are kept twice, in two rows of cells. The front row holds
  // the words front first, the rear row holds them rear first. Each end
  // is therefore always in cell 0 of one row, and every operation is a
  // shift, a single load or a hold in each row, decided locally by each cell.
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] DepthC = CNT_W'(DEPTH);

  logic [CNT_W-1:0]   occ_q;
  logic [CNT_W-1:0]   occ_d;
  logic               out_valid_q;
  dq_status_e         status_q;
  logic [WORD_W-1:0]  front_q;
  logic [WORD_W-1:0]  rear_q;
  logic [COUNT_W-1:0] count_q;
  logic               empty_q;

  dq_ctrl_t           f_ctrl;
  dq_ctrl_t           r_ctrl;
  logic [WORD_W-1:0]  f_head;
  logic [WORD_W-1:0]  f_second;
  logic [WORD_W-1:0]  r_head;
  logic [WORD_W-1:0]  r_second;

  dq_status_e         status_d;
  logic [WORD_W-1:0]  front_d;
  logic [WORD_W-1:0]  rear_d;

  logic accept;
  logic full;
  logic empty;

  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign full        = (occ_q == DepthC);
  assign empty       = (occ_q == '0);

  always_comb begin
    f_ctrl.op   = OP_HOLD;
    r_ctrl.op   = OP_HOLD;
    f_ctrl.word = req_i.value;
    r_ctrl.word = req_i.value;
    occ_d       = occ_q;
    status_d    = ST_OK;
    front_d     = f_head;
    rear_d      = r_head;

    unique case (req_i.mode)
      MODE_PUSH_FRONT: begin
        if (full) begin
          status_d = ST_OVERFLOW;
        end else begin
          f_ctrl.op = OP_INS_HEAD;
          r_ctrl.op = OP_INS_AT;
          occ_d     = occ_q + CNT_W'(1);
          front_d   = req_i.value;
          if (empty) begin
            rear_d = req_i.value;
          end
        end
      end
      MODE_PUSH_REAR: begin
        if (full) begin
          status_d = ST_OVERFLOW;
        end else begin
          f_ctrl.op = OP_INS_AT;
          r_ctrl.op = OP_INS_HEAD;
          occ_d     = occ_q + CNT_W'(1);
          rear_d    = req_i.value;
          if (empty) begin
            front_d = req_i.value;
          end
        end
      end
      MODE_POP_FRONT: begin
        if (empty) begin
          status_d = ST_UNDERFLOW;
        end else begin
          f_ctrl.op = OP_REM_HEAD;
          occ_d     = occ_q - CNT_W'(1);
          front_d   = f_second;
        end
      end
      MODE_POP_REAR: begin
        if (empty) begin
          status_d = ST_UNDERFLOW;
        end else begin
          r_ctrl.op = OP_REM_HEAD;
          occ_d     = occ_q - CNT_W'(1);
          rear_d    = r_second;
        end
      end
    endcase

    // Both ends read as all ones once the queue is empty.
    if (occ_d == '0) begin
      front_d = '1;
      rear_d  = '1;
    end

    if (!accept) begin
      f_ctrl.op = OP_HOLD;
      r_ctrl.op = OP_HOLD;
      occ_d     = occ_q;
    end
  end

  dq_chain #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
  ) u_front_row (
    .clk_i    (clk_i),
    .ctrl_i   (f_ctrl),
    .count_i  (occ_q),
    .head_o   (f_head),
    .second_o (f_second)
  );

  dq_chain #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
  ) u_rear_row (
    .clk_i    (clk_i),
    .ctrl_i   (r_ctrl),
    .count_i  (occ_q),
    .head_o   (r_head),
    .second_o (r_second)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // The count is reported modulo the width of the result field.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      front_q  <= front_d;
      rear_q   <= rear_d;
      count_q  <= COUNT_W'(occ_d);
      empty_q  <= (occ_d == '0);
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = status_q;
  assign rsp_o.front_word = front_q;
  assign rsp_o.rear_word  = rear_q;
  assign rsp_o.count      = count_q;
  assign rsp_o.is_empty   = empty_q;

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= DepthC)
    else $error("word count exceeds depth");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !full && (req_i.mode == MODE_PUSH_FRONT || req_i.mode == MODE_PUSH_REAR)
    |=> occ_q == $past(occ_q) + CNT_W'(1))
    else $error("successful push did not raise the count");

  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && empty && (req_i.mode == MODE_POP_FRONT || req_i.mode == MODE_POP_REAR)
    |=> occ_q == '0 && empty_q)
    else $error("pop on an empty queue left a wrong count");

  a_underflow_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q == ST_UNDERFLOW |-> empty_q && front_q == '1 && rear_q == '1)
    else $error("underflow result does not show an empty queue");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted item produced no result");

endmodule
